// ===== rtl/core/gain_bucket_priority_store_macros.svh =====
// Assertion macros shared by the gain bucket priority store RTL.
// Included by files that carry concurrent assertions; needs nothing else.
`ifndef GAIN_BUCKET_PRIORITY_STORE_MACROS_SVH
`define GAIN_BUCKET_PRIORITY_STORE_MACROS_SVH

// Antecedent in one cycle implies consequent in the next cycle.
`define GBPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define GBPS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/gbps_pkg.sv =====
// Shared types and constants of the gain bucket priority store.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none
package gbps_pkg;
   localparam int OP_W      = 2;
   localparam int KEY_W     = 11;
   localparam int VTX_W     = 10;
   localparam int STATUS_W  = 3;
   localparam int COUNT_W   = 12;
   localparam int WORD_BITS = 32;
   localparam int WORD_SHIFT = 5;

   typedef enum logic [1:0] {
      OP_INSERT, OP_MOVE, OP_DELETE_MAX, OP_CLEAR
   } gbps_op_type;

   typedef enum logic [2:0] {
      STATUS_OK, STATUS_EMPTY, STATUS_SAME_KEY, STATUS_ABSENT, STATUS_PRESENT
   } gbps_status_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RDV, ST_DEC, ST_CLR, ST_T0, ST_T1, ST_T2, ST_T3,
      ST_D1, ST_D2, ST_A1, ST_A2, ST_A3, ST_F0, ST_F1, ST_F2, ST_OUT
   } gbps_state_type;

   typedef struct packed {
      gbps_state_type step;
      logic           accept;
      logic           load;
   } gbps_cmd_type;

   typedef struct packed {
      gbps_op_type op;
      logic        v_ok;
      logic        present;
      logic        same_key;
      logic        any;
   } gbps_stat_type;
endpackage
`default_nettype wire

// ===== rtl/core/gbps_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module gbps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/core/gbps_ctrl.sv =====
// Sequencer of the gain bucket priority store: steps through each operation.
// Depends on gbps_pkg and the assertion macro header.
`default_nettype none
`include "gain_bucket_priority_store_macros.svh"
module gbps_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire gbps_pkg::gbps_stat_type stat,
   output gbps_pkg::gbps_cmd_type      cmd
);
   import gbps_pkg::*;

   gbps_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_RDV;
         ST_RDV:  state_in = ST_DEC;
         ST_DEC: begin
            unique case (stat.op)
               OP_INSERT: state_in = (stat.v_ok && !stat.present) ? ST_A1 : ST_F0;
               OP_MOVE: state_in = (stat.v_ok && stat.present && !stat.same_key) ?
                                   ST_D1 : ST_F0;
               OP_DELETE_MAX: state_in = ST_T0;
               default: state_in = ST_CLR;
            endcase
         end
         ST_CLR: state_in = ST_F0;
         ST_T0:  state_in = stat.any ? ST_T1 : ST_F0;
         ST_T1:  state_in = ST_T2;
         ST_T2:  state_in = ST_T3;
         ST_T3:  state_in = ST_D1;
         ST_D1:  state_in = ST_D2;
         ST_D2:  state_in = (stat.op == OP_MOVE) ? ST_A1 : ST_F0;
         ST_A1:  state_in = ST_A2;
         ST_A2:  state_in = ST_A3;
         ST_A3:  state_in = ST_F0;
         ST_F0:  state_in = stat.any ? ST_F1 : ST_OUT;
         ST_F1:  state_in = ST_F2;
         ST_F2:  state_in = ST_OUT;
         ST_OUT: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      cmd.step   = state_ff;
      cmd.accept = (state_ff == ST_IDLE) && req_tvalid;
      cmd.load   = (state_ff == ST_OUT) && out_free;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `GBPS_ASSERT_NEXT(a_accept_starts, clock, reset, cmd.accept, state_ff == ST_RDV, "accept did not start a transaction")
   `GBPS_ASSERT_NEXT(a_load_shows, clock, reset, cmd.load, rsp_valid_ff && state_ff == ST_IDLE, "result load did not raise valid")
   `GBPS_ASSERT_NEXT(a_empty_search, clock, reset, state_ff == ST_T0 && !stat.any, state_ff == ST_F0, "delete on empty store did not skip")
   `GBPS_ASSERT_NOW(a_busy_no_ready, clock, reset, state_ff != ST_IDLE, !req_tready, "ready while busy")
endmodule
`default_nettype wire

// ===== rtl/core/gbps_dp.sv =====
// Datapath of the gain bucket priority store: link memories, occupancy bitmaps,
// summaries and the result register. Depends on gbps_pkg and gbps_ram.
`default_nettype none
module gbps_dp #(
   parameter int NUM_VERTICES = 1024,
   parameter int GAIN_LIMIT   = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire gbps_pkg::gbps_cmd_type        cmd,
   output gbps_pkg::gbps_stat_type            stat,
   input  wire logic [gbps_pkg::OP_W-1:0]     req_op,
   input  wire logic [gbps_pkg::KEY_W-1:0]    req_key,
   input  wire logic [gbps_pkg::VTX_W-1:0]    req_vertex,
   output logic [gbps_pkg::STATUS_W-1:0]      rsp_status,
   output logic [gbps_pkg::VTX_W-1:0]         rsp_removed_vertex,
   output logic [gbps_pkg::KEY_W-1:0]         rsp_max_key,
   output logic [gbps_pkg::VTX_W-1:0]         rsp_max_vertex,
   output logic                               rsp_not_empty,
   output logic [gbps_pkg::COUNT_W-1:0]       rsp_bucket_count
);
   import gbps_pkg::*;

   localparam int VIW    = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
   localparam int LW     = VIW + 1;
   localparam int NB     = 2 * GAIN_LIMIT;
   localparam int BW     = $clog2(NB);
   localparam int VWORDS = (NUM_VERTICES + WORD_BITS - 1) / WORD_BITS;
   localparam int VWW    = (VWORDS > 1) ? $clog2(VWORDS) : 1;
   localparam int BWORDS = (NB + WORD_BITS - 1) / WORD_BITS;
   localparam int BWW    = (BWORDS > 1) ? $clog2(BWORDS) : 1;
   localparam int CW     = $clog2(NB + 1);
   localparam logic signed [17:0] KEY_LO = 18'(-GAIN_LIMIT);
   localparam logic signed [17:0] KEY_HI = 18'(GAIN_LIMIT - 1);

   gbps_state_type step;
   gbps_op_type op_ff;
   gbps_status_type status_ff;
   logic [BW-1:0] b_ff, kb_ff, top_ff;
   logic [VTX_W-1:0] v_ff;
   logic v_ok_ff, any_ff;
   logic [LW-1:0] p_ff, n_ff, h_ff;
   logic [WORD_BITS-1:0] vword_ff;
   logic [BWW-1:0] topw_ff;
   logic [VWORDS-1:0] vsum_ff;
   logic [BWORDS-1:0] bsum_ff;
   logic [CW-1:0] count_ff;
   logic [VIW-1:0] maxv_ff;

   logic signed [17:0] ks, ksat;
   logic [BW-1:0] b_new;
   logic [VIW-1:0] vidx;
   logic [VWW-1:0] vw;
   logic [4:0] vbit, kbit, bbit, enc_bit;
   logic [BWW-1:0] kbw, bw, enc_w, bsel_w;
   logic [BW-1:0] found;
   logic [WORD_BITS-1:0] veff, beff;
   logic occ, det_empty, present, same_key;
   logic [LW-1:0] h_link;
   logic signed [17:0] mk;

   logic [LW-1:0] next_rd, prev_rd;
   logic [BW-1:0] key_rd;
   logic [VIW-1:0] head_rd;
   logic [WORD_BITS-1:0] vmap_rd, bmap_rd;

   logic next_we, prev_we, key_we, head_we, vmap_we, bmap_we;
   logic [VIW-1:0] next_wa, prev_wa, vtx_ra;
   logic [LW-1:0] next_wd, prev_wd;
   logic [BW-1:0] head_wa, head_ra;
   logic [VIW-1:0] head_wd;
   logic [VWW-1:0] vmap_wa, vmap_ra;
   logic [WORD_BITS-1:0] vmap_wd, bmap_wd;
   logic [BWW-1:0] bmap_wa, bmap_ra;

   assign step = cmd.step;

   always_comb begin
      ks = 18'($signed(req_key));
      ksat = ks;
      if (ks < KEY_LO) ksat = KEY_LO;
      if (ks > KEY_HI) ksat = KEY_HI;
      b_new = BW'(ksat - KEY_LO);
   end

   assign vidx = VIW'(32'(v_ff));
   assign vw   = VWW'(32'(v_ff) >> WORD_SHIFT);
   assign vbit = v_ff[WORD_SHIFT-1:0];
   assign kbw  = BWW'(32'(kb_ff) >> WORD_SHIFT);
   assign kbit = 5'(32'(kb_ff));
   assign bw   = BWW'(32'(b_ff) >> WORD_SHIFT);
   assign bbit = 5'(32'(b_ff));

   // Highest nonempty word of the bucket bitmap, then highest bit inside it.
   always_comb begin
      enc_w = '0;
      for (int i = 0; i < BWORDS; i++) begin
         if (bsum_ff[i]) enc_w = BWW'(i);
      end
      enc_bit = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         if (bmap_rd[j]) enc_bit = 5'(j);
      end
      found = BW'((32'(topw_ff) << WORD_SHIFT) | 32'(enc_bit));
   end

   // Bitmap words whose summary bit is clear read as zero, so a clear
   // only needs to reset the summaries.
   assign veff   = vsum_ff[vw] ? vmap_rd : '0;
   assign bsel_w = (step == ST_D2) ? kbw : bw;
   assign beff   = bsum_ff[bsel_w] ? bmap_rd : '0;
   assign occ    = beff[bbit];
   assign h_link = occ ? {1'b1, head_rd} : '0;
   assign det_empty = !p_ff[VIW] && !n_ff[VIW];
   assign present  = v_ok_ff && veff[vbit];
   assign same_key = (key_rd == b_ff);

   assign stat.op       = op_ff;
   assign stat.v_ok     = v_ok_ff;
   assign stat.present  = present;
   assign stat.same_key = same_key;
   assign stat.any      = |bsum_ff;

   always_comb begin
      vtx_ra  = (step == ST_T2) ? head_rd : vidx;
      vmap_ra = (step == ST_T2) ? VWW'(32'(head_rd) >> WORD_SHIFT) : vw;
      bmap_ra = bw;
      if (step == ST_D1) bmap_ra = kbw;
      if (step == ST_T0 || step == ST_F0) bmap_ra = enc_w;
      head_ra = (step == ST_T1 || step == ST_F1) ? found : b_ff;

      next_we = (step == ST_D1 && p_ff[VIW]) || step == ST_A2;
      next_wa = (step == ST_D1) ? p_ff[VIW-1:0] : vidx;
      next_wd = (step == ST_D1) ? n_ff : h_link;

      prev_we = (step == ST_D1 && n_ff[VIW]) || step == ST_A2 ||
                (step == ST_A3 && h_ff[VIW]);
      prev_wa = vidx;
      prev_wd = '0;
      if (step == ST_D1) begin
         prev_wa = n_ff[VIW-1:0];
         prev_wd = p_ff;
      end else if (step == ST_A3) begin
         prev_wa = h_ff[VIW-1:0];
         prev_wd = {1'b1, vidx};
      end

      key_we  = (step == ST_A2);
      head_we = (step == ST_D1 && !p_ff[VIW]) || step == ST_A2;
      head_wa = (step == ST_D1) ? kb_ff : b_ff;
      head_wd = (step == ST_D1) ? n_ff[VIW-1:0] : vidx;

      vmap_we = (step == ST_D1 && op_ff == OP_DELETE_MAX) ||
                (step == ST_A2 && op_ff == OP_INSERT);
      vmap_wa = vw;
      vmap_wd = (step == ST_D1) ? (vword_ff & ~(WORD_BITS'(1) << vbit)) :
                                  (vword_ff | (WORD_BITS'(1) << vbit));

      bmap_we = (step == ST_D2 && det_empty) || (step == ST_A2 && !occ);
      bmap_wa = (step == ST_D2) ? kbw : bw;
      bmap_wd = (step == ST_D2) ? (beff & ~(WORD_BITS'(1) << kbit)) :
                                  (beff | (WORD_BITS'(1) << bbit));
   end

   gbps_ram #(.WIDTH(LW), .DEPTH(NUM_VERTICES)) u_next (
      .clock, .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_addr(vtx_ra), .rd_data(next_rd));
   gbps_ram #(.WIDTH(LW), .DEPTH(NUM_VERTICES)) u_prev (
      .clock, .wr_en(prev_we), .wr_addr(prev_wa), .wr_data(prev_wd),
      .rd_addr(vtx_ra), .rd_data(prev_rd));
   gbps_ram #(.WIDTH(BW), .DEPTH(NUM_VERTICES)) u_key (
      .clock, .wr_en(key_we), .wr_addr(vidx), .wr_data(b_ff),
      .rd_addr(vtx_ra), .rd_data(key_rd));
   gbps_ram #(.WIDTH(VIW), .DEPTH(NB)) u_head (
      .clock, .wr_en(head_we), .wr_addr(head_wa), .wr_data(head_wd),
      .rd_addr(head_ra), .rd_data(head_rd));
   gbps_ram #(.WIDTH(WORD_BITS), .DEPTH(VWORDS)) u_vmap (
      .clock, .wr_en(vmap_we), .wr_addr(vmap_wa), .wr_data(vmap_wd),
      .rd_addr(vmap_ra), .rd_data(vmap_rd));
   gbps_ram #(.WIDTH(WORD_BITS), .DEPTH(BWORDS)) u_bmap (
      .clock, .wr_en(bmap_we), .wr_addr(bmap_wa), .wr_data(bmap_wd),
      .rd_addr(bmap_ra), .rd_data(bmap_rd));

   always_ff @(posedge clock) begin
      if (reset) begin
         vsum_ff  <= '0;
         bsum_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (vmap_we) vsum_ff[vmap_wa] <= |vmap_wd;
         if (bmap_we) bsum_ff[bmap_wa] <= |bmap_wd;
         if (step == ST_D2 && det_empty) count_ff <= count_ff - CW'(1);
         if (step == ST_A2 && !occ) count_ff <= count_ff + CW'(1);
         if (step == ST_CLR) begin
            vsum_ff  <= '0;
            bsum_ff  <= '0;
            count_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= gbps_op_type'(req_op);
         b_ff    <= b_new;
         v_ff    <= req_vertex;
         v_ok_ff <= 32'(req_vertex) < NUM_VERTICES;
      end
      if (step == ST_DEC || step == ST_T3) begin
         p_ff     <= prev_rd;
         n_ff     <= next_rd;
         kb_ff    <= key_rd;
         vword_ff <= veff;
      end
      if (step == ST_DEC) begin
         unique case (op_ff)
            OP_INSERT: status_ff <= !v_ok_ff ? STATUS_ABSENT :
                                    present ? STATUS_PRESENT : STATUS_OK;
            OP_MOVE: status_ff <= !present ? STATUS_ABSENT :
                                  same_key ? STATUS_SAME_KEY : STATUS_OK;
            default: status_ff <= STATUS_OK;
         endcase
      end
      if (step == ST_T0) status_ff <= stat.any ? STATUS_OK : STATUS_EMPTY;
      if (step == ST_T0 || step == ST_F0) topw_ff <= enc_w;
      if (step == ST_T2) v_ff <= VTX_W'(32'(head_rd));
      if (step == ST_A2) h_ff <= h_link;
      if (step == ST_F0) any_ff <= stat.any;
      if (step == ST_F1) top_ff <= found;
      if (step == ST_F2) maxv_ff <= head_rd;
      if (cmd.load) begin
         rsp_status <= status_ff;
         rsp_removed_vertex <= (op_ff == OP_DELETE_MAX && status_ff == STATUS_OK) ?
                               v_ff : '0;
         rsp_max_key      <= any_ff ? KEY_W'(mk) : '0;
         rsp_max_vertex   <= any_ff ? VTX_W'(32'(maxv_ff)) : '0;
         rsp_not_empty    <= any_ff;
         rsp_bucket_count <= COUNT_W'(32'(count_ff));
      end
   end

   assign mk = 18'(32'(top_ff)) - 18'(GAIN_LIMIT);
endmodule
`default_nettype wire

// ===== rtl/core/gain_bucket_priority_store.sv =====
// Top level of the gain bucket priority store: controller plus datapath.
// Depends on gbps_pkg, gbps_ctrl, gbps_dp and gbps_ram.
//
// Usage: a request transaction on req_* carries an operation in req_tuser
// (insert, move, delete maximum, clear) with a key and a vertex in req_tdata.
// Every request yields exactly one response transaction on rsp_* with a
// status in rsp_tuser and the store's maximum key, its head vertex, the
// removed vertex, a nonempty flag and the occupied key count in rsp_tdata.
// One request is handled at a time: req_tready is high only while idle.
// The time from acceptance to rsp_tvalid depends on the operation, on
// whether the request is rejected and on whether the store is empty; it is
// set by the chain of dependent pointer reads and writes in the link memories
// and the two-level search of the occupancy bitmap. The next request is taken
// in the cycle after the response is loaded.
// The response waits in an output register; while the receiver stalls, the
// store finishes the next request's work and holds it until the slot frees.
// Reset clears the bitmap summaries and the key count, which empties the
// store at once; no clearing pass runs and the first request may follow.
`default_nettype none
module gain_bucket_priority_store #(
   parameter int NUM_VERTICES = 1024,
   parameter int GAIN_LIMIT   = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // key[10:0], vertex[20:11], zero fill
   input  wire logic [1:0]  req_tuser,  // op[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,  // removed_vertex, max_key, max_vertex,
                                        // not_empty, bucket_count, zero fill
   output logic [2:0]       rsp_tuser   // status[2:0]
);
   import gbps_pkg::*;

   gbps_cmd_type  cmd;
   gbps_stat_type stat;
   logic [STATUS_W-1:0] status;
   logic [VTX_W-1:0] removed_vertex, max_vertex;
   logic [KEY_W-1:0] max_key;
   logic not_empty;
   logic [COUNT_W-1:0] bucket_count;

   gbps_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .stat, .cmd);

   gbps_dp #(.NUM_VERTICES(NUM_VERTICES), .GAIN_LIMIT(GAIN_LIMIT)) u_dp (
      .clock, .reset, .cmd, .stat,
      .req_op(req_tuser), .req_key(req_tdata[10:0]), .req_vertex(req_tdata[20:11]),
      .rsp_status(status), .rsp_removed_vertex(removed_vertex),
      .rsp_max_key(max_key), .rsp_max_vertex(max_vertex),
      .rsp_not_empty(not_empty), .rsp_bucket_count(bucket_count));

   assign rsp_tuser = status;
   assign rsp_tdata = {4'b0, bucket_count, not_empty, max_vertex, max_key, removed_vertex};
endmodule
`default_nettype wire
